// ----- rtl/yisd_pkg.sv -----
// ----------------------------------------------------------------------------
// Y86-64 instruction stream decoder package
// Item kind codes, decode mode type, result record type and opcode tables
// shared by the decoder, its result queue and its checker.
// ----------------------------------------------------------------------------
package yisd_pkg;

   // Item kind codes as shown on rsp_item_kind
   localparam logic [3:0] KIND_HALT   = 4'd0;
   localparam logic [3:0] KIND_NOP    = 4'd1;
   localparam logic [3:0] KIND_RRMOVQ = 4'd2;
   localparam logic [3:0] KIND_CMOV   = 4'd3;
   localparam logic [3:0] KIND_IRMOVQ = 4'd4;
   localparam logic [3:0] KIND_RMMOVQ = 4'd5;
   localparam logic [3:0] KIND_MRMOVQ = 4'd6;
   localparam logic [3:0] KIND_OP     = 4'd7;
   localparam logic [3:0] KIND_JUMP   = 4'd8;
   localparam logic [3:0] KIND_CALL   = 4'd9;
   localparam logic [3:0] KIND_RET    = 4'd10;
   localparam logic [3:0] KIND_PUSH   = 4'd11;
   localparam logic [3:0] KIND_POP    = 4'd12;
   localparam logic [3:0] KIND_QUAD   = 4'd13;
   localparam logic [3:0] KIND_BYTE   = 4'd14;

   localparam logic [3:0] NO_REG      = 4'hF;
   localparam logic [3:0] MAX_FUNC    = 4'd6;
   localparam logic [3:0] QUAD_LEN    = 4'd8;

   localparam int PEND_DEPTH        = 10;
   localparam int DEFAULT_RSP_DEPTH = 2;

   typedef enum logic [1:0] {
      MODE_OPCODE,
      MODE_REG,
      MODE_CONST,
      MODE_QUAD
   } mode_type;

   typedef struct packed {
      logic [63:0] address;
      logic [3:0]  kind;
      logic [3:0]  func;
      logic [3:0]  reg_a;
      logic [3:0]  reg_b;
      logic [63:0] value;
      logic [3:0]  length;
      logic        last;
   } record_type;

   function automatic logic [3:0] kind_of(input logic [7:0] op);
      logic [3:0] lo;
      logic [3:0] k;
      lo = op[3:0];
      unique case (op[7:4])
         4'h0: k = (lo == 4'd0) ? KIND_HALT : KIND_QUAD;
         4'h1: k = (lo == 4'd0) ? KIND_NOP : KIND_QUAD;
         4'h2: k = (lo == 4'd0) ? KIND_RRMOVQ : ((lo <= MAX_FUNC) ? KIND_CMOV : KIND_QUAD);
         4'h3: k = (lo == 4'd0) ? KIND_IRMOVQ : KIND_QUAD;
         4'h4: k = (lo == 4'd0) ? KIND_RMMOVQ : KIND_QUAD;
         4'h5: k = (lo == 4'd0) ? KIND_MRMOVQ : KIND_QUAD;
         4'h6: k = (lo <= MAX_FUNC) ? KIND_OP : KIND_QUAD;
         4'h7: k = (lo <= MAX_FUNC) ? KIND_JUMP : KIND_QUAD;
         4'h8: k = (lo == 4'd0) ? KIND_CALL : KIND_QUAD;
         4'h9: k = (lo == 4'd0) ? KIND_RET : KIND_QUAD;
         4'hA: k = (lo == 4'd0) ? KIND_PUSH : KIND_QUAD;
         4'hB: k = (lo == 4'd0) ? KIND_POP : KIND_QUAD;
         default: k = KIND_QUAD;
      endcase
      return k;
   endfunction

   function automatic logic [3:0] length_of(input logic [3:0] kind);
      logic [3:0] len;
      unique case (kind)
         KIND_HALT, KIND_NOP, KIND_RET:          len = 4'd1;
         KIND_IRMOVQ, KIND_RMMOVQ, KIND_MRMOVQ:  len = 4'd10;
         KIND_JUMP, KIND_CALL:                   len = 4'd9;
         KIND_QUAD:                              len = QUAD_LEN;
         default:                                len = 4'd2;
      endcase
      return len;
   endfunction

   function automatic logic regs_ok(input logic [3:0] kind, input logic [7:0] rb_byte);
      logic ok;
      unique case (kind)
         KIND_IRMOVQ:         ok = (rb_byte[7:4] == NO_REG) && (rb_byte[3:0] != NO_REG);
         KIND_PUSH, KIND_POP: ok = (rb_byte[7:4] != NO_REG) && (rb_byte[3:0] == NO_REG);
         default:             ok = (rb_byte[7:4] != NO_REG) && (rb_byte[3:0] != NO_REG);
      endcase
      return ok;
   endfunction

endpackage

// ----- rtl/yisd_rsp_fifo.sv -----
// ----------------------------------------------------------------------------
// Result record queue
// Small register queue between the decode logic and the result channel, so
// the decoder keeps taking bytes while a record waits to be taken.
// ----------------------------------------------------------------------------
module yisd_rsp_fifo #(
   parameter int DEPTH = yisd_pkg::DEFAULT_RSP_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  yisd_pkg::record_type   push_data,
   output logic                   full,
   output logic                   out_valid,
   input  logic                   out_stall,
   output yisd_pkg::record_type   out_data
);
   import yisd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   record_type         entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign out_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_data  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/y86_instruction_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// Y86-64 instruction stream decoder
// Splits a machine-code byte stream into instruction and data records.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while req_stall is low, and presents
// the record that a byte completes through a small result queue, so a held
// result does not stop the byte stream until the queue fills. Only the last
// byte of a stream (req_stream_end) can cost more: if it ends inside an
// unfinished instruction, the pending bytes are flushed as one record per
// cycle while the queue has room (up to seven .byte records, or a .quad and
// at most one .byte record), and req_stall stays high until the flush has
// been queued. Writing csr_start_address sets the address of the next
// stream's first byte and reloads the running address at once.
module y86_instruction_stream_decoder_unit #(
   parameter int RSP_DEPTH = yisd_pkg::DEFAULT_RSP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_item_address,
   output logic [3:0]  rsp_item_kind,
   output logic [3:0]  rsp_function_code,
   output logic [3:0]  rsp_reg_a,
   output logic [3:0]  rsp_reg_b,
   output logic [63:0] rsp_constant_value,
   output logic [3:0]  rsp_item_length,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_start_address
);
   import yisd_pkg::*;

   mode_type     mode_ff, mode_in;
   logic [3:0]   count_ff, count_in;
   logic [63:0]  addr_ff, addr_in;
   logic [63:0]  start_ff, start_in;
   logic         halt_sup_ff, halt_sup_in;
   logic         flush_busy_ff, flush_busy_in;
   logic [3:0]   flush_cnt_ff, flush_cnt_in;
   logic [3:0]   flush_idx_ff, flush_idx_in;
   logic [63:0]  flush_addr_ff, flush_addr_in;
   logic [7:0]   pend_ff   [PEND_DEPTH];
   logic [7:0]   pend_next [PEND_DEPTH];

   logic         req_accept;
   logic         fifo_full;
   logic [3:0]   wr_idx;
   logic [3:0]   op_kind;
   logic [3:0]   cur_kind;
   logic [3:0]   cur_len;
   logic [3:0]   cnt_inc;
   logic [3:0]   flush_next_idx;
   logic         push;
   record_type   rec;
   record_type   rsp_rec;

   assign req_stall  = flush_busy_ff || fifo_full;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !flush_busy_ff;

   assign wr_idx   = (mode_ff == MODE_OPCODE) ? 4'd0 : count_ff;
   assign op_kind  = kind_of(req_code_byte);
   assign cur_kind = kind_of(pend_ff[0]);
   assign cur_len  = length_of(cur_kind);
   assign cnt_inc  = count_ff + 4'd1;

   always_comb begin
      for (int i = 0; i < PEND_DEPTH; i++) begin
         pend_next[i] = (wr_idx == 4'(i)) ? req_code_byte : pend_ff[i];
      end
   end

   assign flush_next_idx = (flush_idx_ff == 4'd0 && flush_cnt_ff >= QUAD_LEN) ?
                           QUAD_LEN : flush_idx_ff + 4'd1;

   always_comb begin
      mode_in       = mode_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      start_in      = start_ff;
      halt_sup_in   = halt_sup_ff;
      flush_busy_in = flush_busy_ff;
      flush_cnt_in  = flush_cnt_ff;
      flush_idx_in  = flush_idx_ff;
      flush_addr_in = flush_addr_ff;
      push          = 1'b0;
      rec.address   = addr_ff;
      rec.kind      = cur_kind;
      rec.func      = pend_ff[0][3:0];
      rec.reg_a     = NO_REG;
      rec.reg_b     = NO_REG;
      rec.value     = '0;
      rec.length    = cur_len;
      rec.last      = 1'b1;

      if (req_accept) begin
         unique case (mode_ff)
            MODE_OPCODE: begin
               count_in = 4'd1;
               if (op_kind == KIND_HALT) begin
                  // report a halt only when it does not follow a halt or start
                  push        = !halt_sup_ff;
                  rec.kind    = KIND_HALT;
                  rec.func    = 4'd0;
                  rec.length  = 4'd1;
                  halt_sup_in = 1'b1;
                  addr_in     = addr_ff + 64'd1;
                  count_in    = 4'd0;
               end else begin
                  halt_sup_in = 1'b0;
                  if (length_of(op_kind) == 4'd1) begin
                     push       = 1'b1;
                     rec.kind   = op_kind;
                     rec.func   = req_code_byte[3:0];
                     rec.length = 4'd1;
                     addr_in    = addr_ff + 64'd1;
                     count_in   = 4'd0;
                  end else if (op_kind == KIND_QUAD) begin
                     mode_in = MODE_QUAD;
                  end else if (op_kind == KIND_JUMP || op_kind == KIND_CALL) begin
                     mode_in = MODE_CONST;
                  end else begin
                     mode_in = MODE_REG;
                  end
               end
            end
            MODE_REG: begin
               count_in = cnt_inc;
               if (!regs_ok(cur_kind, req_code_byte)) begin
                  mode_in = MODE_QUAD;
               end else if (cur_len == 4'd2) begin
                  push      = 1'b1;
                  rec.reg_a = req_code_byte[7:4];
                  rec.reg_b = req_code_byte[3:0];
                  addr_in   = addr_ff + 64'(cur_len);
                  count_in  = 4'd0;
                  mode_in   = MODE_OPCODE;
               end else begin
                  mode_in = MODE_CONST;
               end
            end
            MODE_CONST: begin
               count_in = cnt_inc;
               if (cnt_inc >= cur_len) begin
                  push = 1'b1;
                  if (cur_len == 4'd10) begin
                     rec.reg_a = pend_next[1][7:4];
                     rec.reg_b = pend_next[1][3:0];
                     rec.value = {pend_next[9], pend_next[8], pend_next[7], pend_next[6],
                                  pend_next[5], pend_next[4], pend_next[3], pend_next[2]};
                  end else begin
                     rec.value = {pend_next[8], pend_next[7], pend_next[6], pend_next[5],
                                  pend_next[4], pend_next[3], pend_next[2], pend_next[1]};
                  end
                  addr_in  = addr_ff + 64'(cur_len);
                  count_in = 4'd0;
                  mode_in  = MODE_OPCODE;
               end
            end
            MODE_QUAD: begin
               count_in = cnt_inc;
               if (cnt_inc >= QUAD_LEN) begin
                  push       = 1'b1;
                  rec.kind   = KIND_QUAD;
                  rec.func   = 4'd0;
                  rec.value  = {pend_next[7], pend_next[6], pend_next[5], pend_next[4],
                                pend_next[3], pend_next[2], pend_next[1], pend_next[0]};
                  rec.length = QUAD_LEN;
                  addr_in    = addr_ff + 64'(QUAD_LEN);
                  count_in   = 4'd0;
                  mode_in    = MODE_OPCODE;
               end
            end
            default: begin
               mode_in = MODE_OPCODE;
            end
         endcase

         if (req_stream_end) begin
            // hand the unfinished item to the flush sequencer, restart the stream
            if (count_in != 4'd0) begin
               flush_busy_in = 1'b1;
               flush_cnt_in  = count_in;
               flush_idx_in  = 4'd0;
               flush_addr_in = addr_in;
            end
            count_in    = 4'd0;
            mode_in     = MODE_OPCODE;
            halt_sup_in = 1'b1;
            addr_in     = start_ff;
         end
      end else if (flush_busy_ff && !fifo_full) begin
         push        = 1'b1;
         rec.func    = 4'd0;
         rec.last    = (flush_next_idx == flush_cnt_ff);
         if (flush_idx_ff == 4'd0 && flush_cnt_ff >= QUAD_LEN) begin
            rec.address = flush_addr_ff;
            rec.kind    = KIND_QUAD;
            rec.value   = {pend_ff[7], pend_ff[6], pend_ff[5], pend_ff[4],
                           pend_ff[3], pend_ff[2], pend_ff[1], pend_ff[0]};
            rec.length  = QUAD_LEN;
         end else begin
            rec.address = flush_addr_ff + 64'(flush_idx_ff);
            rec.kind    = KIND_BYTE;
            rec.value   = {56'd0, pend_ff[flush_idx_ff]};
            rec.length  = 4'd1;
         end
         flush_idx_in = flush_next_idx;
         if (rec.last) begin
            flush_busy_in = 1'b0;
         end
      end

      if (csr_valid && csr_ready) begin
         start_in = csr_start_address;
         addr_in  = csr_start_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OPCODE;
         count_ff      <= 4'd0;
         addr_ff       <= '0;
         start_ff      <= '0;
         halt_sup_ff   <= 1'b1;
         flush_busy_ff <= 1'b0;
         flush_cnt_ff  <= 4'd0;
         flush_idx_ff  <= 4'd0;
      end else begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         addr_ff       <= addr_in;
         start_ff      <= start_in;
         halt_sup_ff   <= halt_sup_in;
         flush_busy_ff <= flush_busy_in;
         flush_cnt_ff  <= flush_cnt_in;
         flush_idx_ff  <= flush_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_addr_ff <= flush_addr_in;
      if (req_accept) begin
         pend_ff[wr_idx] <= req_code_byte;
      end
   end

   yisd_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (rec),
      .full      (fifo_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_rec)
   );

   assign rsp_item_address   = rsp_rec.address;
   assign rsp_item_kind      = rsp_rec.kind;
   assign rsp_function_code  = rsp_rec.func;
   assign rsp_reg_a          = rsp_rec.reg_a;
   assign rsp_reg_b          = rsp_rec.reg_b;
   assign rsp_constant_value = rsp_rec.value;
   assign rsp_item_length    = rsp_rec.length;
   assign rsp_run_last       = rsp_rec.last;

endmodule

// ----- rtl/yisd_checker.sv -----
// ----------------------------------------------------------------------------
// Y86-64 instruction stream decoder checker
// Port-level checks on the result channel, bound to the decoder top level.
// ----------------------------------------------------------------------------
module yisd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_item_address,
   input logic [3:0]  rsp_item_kind,
   input logic [3:0]  rsp_function_code,
   input logic [3:0]  rsp_reg_a,
   input logic [3:0]  rsp_reg_b,
   input logic [63:0] rsp_constant_value,
   input logic [3:0]  rsp_item_length,
   input logic        rsp_run_last
);
   import yisd_pkg::*;

   // a held result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item_address)
         && $stable(rsp_item_kind) && $stable(rsp_constant_value)
         && $stable(rsp_run_last))
      else $error("result transaction changed while stalled");

   a_byte_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_BYTE |->
         rsp_item_length == 4'd1 && rsp_constant_value[63:8] == 56'd0
         && rsp_reg_a == NO_REG && rsp_reg_b == NO_REG && rsp_function_code == 4'd0)
      else $error("malformed byte record");

   a_quad_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_QUAD |->
         rsp_item_length == QUAD_LEN && rsp_function_code == 4'd0
         && rsp_reg_a == NO_REG && rsp_reg_b == NO_REG)
      else $error("malformed quad record");

   // flushed byte records come back to back at consecutive addresses
   a_flush_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_item_kind == KIND_BYTE && !rsp_run_last |=>
         rsp_valid && rsp_item_kind == KIND_BYTE
         && rsp_item_address == $past(rsp_item_address) + 64'd1)
      else $error("flush byte records not contiguous");

endmodule

bind y86_instruction_stream_decoder_unit yisd_checker u_yisd_checker (.*);
